>>> hw/rtl/spp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants of the parity partition stack
// Sizes, command and status codes, controller to datapath bundles.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int DEPTH_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PART = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH,
        DP_FULL,
        DP_EMPTY,
        DP_POP_RD,
        DP_POP_CAP,
        DP_PART_INIT,
        DP_SCAN_RD,
        DP_SCAN_WR,
        DP_MERGE_RD,
        DP_MERGE_WR,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             scan_last;
        logic             odd_none;
        logic             merge_last;
        logic             out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/spp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_if: command and result channels of the parity partition stack
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface spp_req_if;
    logic                                valid;
    logic                                ready;
    logic [spp_pkg::CMD_W-1:0]           cmd;
    logic signed [spp_pkg::WORD_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface spp_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [spp_pkg::WORD_W-1:0]   popped;
    logic [spp_pkg::STAT_W-1:0]          status;
    logic [spp_pkg::DEPTH_W-1:0]         depth;

    modport source (output valid, output popped, output status, output depth, input ready);
    modport sink   (input valid, input popped, input status, input depth, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/stack_with_parity_partition_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_parity_partition_top: LIFO stack with stable even/odd partition
// Commands arrive on req (cmd, value); each gives one transfer on rsp
// (popped, status, depth). cmd 0 pushes, 1 pops, 2 moves even words below
// odd words keeping each group's order; code 3 does nothing and reports ok.
// Each command is loaded, executed and then finished; a pop adds a capture
// of the registered read, and a partition of n words scans each word with a
// read and a write, then merges each of the m odd words from the odd-word
// buffer with a read and a write. One command is in work at a time;
// req.ready is high only while no command is in work, and a new command is
// taken while the previous result still waits in the output register.
// If rsp.ready is low the finished result holds in the sequencer until the
// output register is free. Reset empties the stack and the output register;
// memory contents are not cleared and no reset pass is needed.
// ----------------------------------------------------------------------------
module stack_with_parity_partition_top (
    input  wire logic clk,
    input  wire logic rst_n,
    spp_req_if.sink   req,
    spp_rsp_if.source rsp
);

    spp_pkg::dp_ctrl_t ctrl;
    spp_pkg::dp_stat_t stat;

    spp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    spp_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

>>> hw/rtl/spp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/spp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_datapath: storage, counters and result register
// Holds the fill count, the scan indexes, the two word memories and the
// output register; executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module spp_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spp_pkg::dp_ctrl_t ctrl,
    output spp_pkg::dp_stat_t      stat,
    spp_req_if.sink                req,
    spp_rsp_if.source              rsp
);

    logic [spp_pkg::CMD_W-1:0]  cmd_reg;
    logic [spp_pkg::WORD_W-1:0] value_reg;
    logic [spp_pkg::CNT_W-1:0]  fill_reg;
    logic [spp_pkg::CNT_W-1:0]  idx_reg;
    logic [spp_pkg::CNT_W-1:0]  evens_reg;
    logic [spp_pkg::CNT_W-1:0]  odds_reg;
    logic [spp_pkg::WORD_W-1:0] popped_reg;
    logic [spp_pkg::STAT_W-1:0] status_reg;
    logic                       out_valid_reg;
    logic [spp_pkg::WORD_W-1:0] out_popped_reg;
    logic [spp_pkg::STAT_W-1:0] out_status_reg;
    logic [spp_pkg::DEPTH_W-1:0] out_depth_reg;

    logic                        stk_we;
    logic [spp_pkg::ADDR_W-1:0]  stk_waddr;
    logic [spp_pkg::WORD_W-1:0]  stk_wdata;
    logic [spp_pkg::ADDR_W-1:0]  stk_raddr;
    logic [spp_pkg::WORD_W-1:0]  stk_rdata;
    logic                        odd_we;
    logic [spp_pkg::ADDR_W-1:0]  odd_raddr;
    logic [spp_pkg::WORD_W-1:0]  odd_rdata;
    logic [spp_pkg::CNT_W-1:0]   fill_dec;
    logic [spp_pkg::CNT_W-1:0]   merge_addr;
    logic                        word_odd;

    assign fill_dec   = fill_reg - 1'b1;
    assign merge_addr = evens_reg + idx_reg;
    assign word_odd   = stk_rdata[0];

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = fill_reg[spp_pkg::ADDR_W-1:0];
        stk_wdata = value_reg;
        stk_raddr = idx_reg[spp_pkg::ADDR_W-1:0];
        odd_we    = 1'b0;
        odd_raddr = idx_reg[spp_pkg::ADDR_W-1:0];
        case (ctrl.op)
            spp_pkg::DP_PUSH:
            begin
                stk_we = 1'b1;
            end
            spp_pkg::DP_POP_RD:
            begin
                stk_raddr = fill_dec[spp_pkg::ADDR_W-1:0];
            end
            spp_pkg::DP_SCAN_WR:
            begin
                stk_we    = !word_odd;
                stk_waddr = evens_reg[spp_pkg::ADDR_W-1:0];
                stk_wdata = stk_rdata;
                odd_we    = word_odd;
            end
            spp_pkg::DP_MERGE_WR:
            begin
                stk_we    = 1'b1;
                stk_waddr = merge_addr[spp_pkg::ADDR_W-1:0];
                stk_wdata = odd_rdata;
            end
            default:
            begin
            end
        endcase
    end

    spp_ram #(.WIDTH(spp_pkg::WORD_W), .DEPTH(spp_pkg::DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    spp_ram #(.WIDTH(spp_pkg::WORD_W), .DEPTH(spp_pkg::DEPTH)) u_odd_ram (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odds_reg[spp_pkg::ADDR_W-1:0]),
        .wdata (stk_rdata),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.op == spp_pkg::DP_PUSH)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (ctrl.op == spp_pkg::DP_POP_RD)
            begin
                fill_reg <= fill_dec;
            end
            if (ctrl.op == spp_pkg::DP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            spp_pkg::DP_LOAD:
            begin
                cmd_reg    <= req.cmd;
                value_reg  <= req.value;
                popped_reg <= '0;
                status_reg <= spp_pkg::ST_OK;
            end
            spp_pkg::DP_FULL:
            begin
                status_reg <= spp_pkg::ST_FULL;
            end
            spp_pkg::DP_EMPTY:
            begin
                status_reg <= spp_pkg::ST_EMPTY;
            end
            spp_pkg::DP_POP_CAP:
            begin
                popped_reg <= stk_rdata;
            end
            spp_pkg::DP_PART_INIT:
            begin
                idx_reg   <= '0;
                evens_reg <= '0;
                odds_reg  <= '0;
            end
            spp_pkg::DP_SCAN_WR:
            begin
                if (word_odd)
                begin
                    odds_reg <= odds_reg + 1'b1;
                end
                else
                begin
                    evens_reg <= evens_reg + 1'b1;
                end
                idx_reg <= stat.scan_last ? '0 : idx_reg + 1'b1;
            end
            spp_pkg::DP_MERGE_WR:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            spp_pkg::DP_OUT:
            begin
                out_popped_reg <= popped_reg;
                out_status_reg <= status_reg;
                out_depth_reg  <= spp_pkg::DEPTH_W'(fill_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.full       = (fill_reg == spp_pkg::CNT_W'(spp_pkg::DEPTH));
        stat.empty      = (fill_reg == '0);
        stat.scan_last  = (idx_reg + 1'b1 == fill_reg);
        stat.odd_none   = (odds_reg == '0) && !word_odd;
        stat.merge_last = (idx_reg + 1'b1 == odds_reg);
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.popped = out_popped_reg;
    assign rsp.status = out_status_reg;
    assign rsp.depth  = out_depth_reg;

endmodule
`default_nettype wire

>>> hw/rtl/spp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_ctrl: command sequencer of the parity partition stack
// Steps commands through the datapath, one op per cycle; stalls in S_FINISH.
// ----------------------------------------------------------------------------
module spp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire spp_pkg::dp_stat_t stat,
    output spp_pkg::dp_ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_WR,
        S_MERGE_RD,
        S_MERGE_WR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = spp_pkg::DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.op    = spp_pkg::DP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                case (stat.cmd)
                    spp_pkg::CMD_PUSH:
                    begin
                        ctrl.op = stat.full ? spp_pkg::DP_FULL : spp_pkg::DP_PUSH;
                    end
                    spp_pkg::CMD_POP:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.op = spp_pkg::DP_EMPTY;
                        end
                        else
                        begin
                            ctrl.op    = spp_pkg::DP_POP_RD;
                            state_next = S_POP_WAIT;
                        end
                    end
                    spp_pkg::CMD_PART:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.op = spp_pkg::DP_EMPTY;
                        end
                        else
                        begin
                            ctrl.op    = spp_pkg::DP_PART_INIT;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                ctrl.op    = spp_pkg::DP_POP_CAP;
                state_next = S_FINISH;
            end
            S_SCAN_RD:
            begin
                ctrl.op    = spp_pkg::DP_SCAN_RD;
                state_next = S_SCAN_WR;
            end
            S_SCAN_WR:
            begin
                ctrl.op = spp_pkg::DP_SCAN_WR;
                if (!stat.scan_last)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (stat.odd_none)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_MERGE_RD;
                end
            end
            S_MERGE_RD:
            begin
                ctrl.op    = spp_pkg::DP_MERGE_RD;
                state_next = S_MERGE_WR;
            end
            S_MERGE_WR:
            begin
                ctrl.op    = spp_pkg::DP_MERGE_WR;
                state_next = stat.merge_last ? S_FINISH : S_MERGE_RD;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = spp_pkg::DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/spp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_checker: port-level checks of the parity partition stack
// Watches the result channel and the request handshake.
// ----------------------------------------------------------------------------
module spp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [spp_pkg::WORD_W-1:0]    rsp_popped,
    input wire logic [spp_pkg::STAT_W-1:0]    rsp_status,
    input wire logic [spp_pkg::DEPTH_W-1:0]   rsp_depth
);

    localparam logic [spp_pkg::DEPTH_W-1:0] MAX_DEPTH = spp_pkg::DEPTH_W'(spp_pkg::DEPTH);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped)
            && $stable(rsp_status) && $stable(rsp_depth))
        else $error("result changed while stalled");

    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == spp_pkg::ST_FULL |-> rsp_depth == MAX_DEPTH)
        else $error("full status with stack not full");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != spp_pkg::ST_OK |-> rsp_popped == '0)
        else $error("failed command returned a word");

    a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == spp_pkg::ST_EMPTY |-> rsp_depth == '0)
        else $error("empty status with words stored");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a command is in work");

endmodule

bind stack_with_parity_partition_top spp_checker u_spp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_popped (rsp.popped),
    .rsp_status (rsp.status),
    .rsp_depth  (rsp.depth)
);
`default_nettype wire
